// File: src/ordered_list_engine_assert.svh
// Assertion macros shared by the ordered list engine RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Condition that holds at every clock edge.
`define OLE_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define OLE_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OLE_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ole_pkg.sv
// Package for the ordered list engine: sizes, beat types, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SWAP   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_SHORT     = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                         mode;
    logic signed [WORD_WIDTH-1:0]  value;
  } item_t;

  typedef struct packed {
    status_t                       status;
    logic [CNT_W-1:0]              list_length;
    logic signed [WORD_WIDTH-1:0]  element;
    logic                          element_valid;
    logic                          last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN_REQ,
    S_SCAN_CMP,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_SWAP_RD1,
    S_SWAP_RD2,
    S_SWAP_WR1,
    S_SWAP_WR2,
    S_READ_REQ,
    S_READ_EMIT,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    ASEL_IDX,
    ASEL_IDX_P1,
    ASEL_ONE,
    ASEL_LAST,
    ASEL_COUNT
  } addr_sel_t;

  typedef enum logic [1:0] {
    WSEL_KEY,
    WSEL_RDATA,
    WSEL_TMP
  } wdata_sel_t;

  typedef struct packed {
    logic        capture;
    logic        idx_inc;
    logic        rd_en;
    addr_sel_t   rd_sel;
    logic        wr_en;
    addr_sel_t   wr_sel;
    wdata_sel_t  wdata_sel;
    logic        tmp_load;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        set_status;
    status_t     status_code;
    logic        out_load;
    logic        out_elem;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic short_list;
    logic idx_at_end;
    logic idx_last;
    logic match;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/ole_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold the last read word while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/ole_datapath.sv
// Datapath of the ordered list engine: entry RAM, count, index, key and
// swap holding registers, status and the result output register. Uses ole_pkg, ole_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_assert.svh"

module ole_datapath import ole_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dp_cmd_t                       cmd,
  input  wire logic signed [WORD_WIDTH-1:0]  item_value,
  input  wire logic                          result_stall,
  output dp_status_t                         status,
  output logic                               result_valid,
  output result_t                            result
);

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             idx;
  logic signed [WORD_WIDTH-1:0] key;
  logic [WORD_WIDTH-1:0]        tmp;
  status_t                      status_reg;
  result_t                      out_reg;
  logic                         out_valid;

  logic [CNT_W-1:0]      idx_p1;
  logic [CNT_W-1:0]      last_pos;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [WORD_WIDTH-1:0] rd_data;

  assign idx_p1   = idx + 1'b1;
  assign last_pos = count - 1'b1;

  function automatic logic [IDX_W-1:0] pick_addr(
    input addr_sel_t        sel,
    input logic [CNT_W-1:0] i,
    input logic [CNT_W-1:0] ip1,
    input logic [CNT_W-1:0] lst,
    input logic [CNT_W-1:0] cnt
  );
    logic [IDX_W-1:0] a;
    case (sel)
      ASEL_IDX:    a = i[IDX_W-1:0];
      ASEL_IDX_P1: a = ip1[IDX_W-1:0];
      ASEL_ONE:    a = IDX_W'(1);
      ASEL_LAST:   a = lst[IDX_W-1:0];
      ASEL_COUNT:  a = cnt[IDX_W-1:0];
      default:     a = '0;
    endcase
    return a;
  endfunction

  assign rd_addr = pick_addr(cmd.rd_sel, idx, idx_p1, last_pos, count);
  assign wr_addr = pick_addr(cmd.wr_sel, idx, idx_p1, last_pos, count);

  always_comb begin
    case (cmd.wdata_sel)
      WSEL_KEY:   wr_data = key;
      WSEL_RDATA: wr_data = rd_data;
      WSEL_TMP:   wr_data = tmp;
      default:    wr_data = key;
    endcase
  end

  ole_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_p1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key <= item_value;
    end
    if (cmd.tmp_load) begin
      tmp <= rd_data;
    end
    if (cmd.capture) begin
      status_reg <= STAT_OK;
    end else if (cmd.set_status) begin
      status_reg <= cmd.status_code;
    end
    if (cmd.out_load) begin
      out_reg.list_length <= count;
      if (cmd.out_elem) begin
        out_reg.status        <= STAT_OK;
        out_reg.element       <= rd_data;
        out_reg.element_valid <= 1'b1;
        out_reg.last          <= status.idx_last;
      end else begin
        out_reg.status        <= status_reg;
        out_reg.element       <= '0;
        out_reg.element_valid <= 1'b0;
        out_reg.last          <= 1'b1;
      end
    end
  end

  assign status.full       = (count == CNT_W'(DEPTH));
  assign status.empty      = (count == '0);
  assign status.short_list = (count < CNT_W'(3));
  assign status.idx_at_end = (idx == count);
  assign status.idx_last   = (idx_p1 == count);
  assign status.match      = (rd_data == key);
  assign status.slot_free  = !out_valid || !result_stall;

  assign result_valid = out_valid;
  assign result       = out_reg;

  `OLE_CHECK(a_count_bound, count <= CNT_W'(DEPTH), "entry count above depth")
  `OLE_IMPLY(a_load_free, cmd.out_load, status.slot_free, "result loaded over a waiting beat")
  `OLE_IMPLY(a_elem_ok, result_valid && result.element_valid, result.status == STAT_OK,
             "entry beat carries a non-ok status")
  `OLE_NEXT(a_inc_not_full, cmd.cnt_inc, count != '0, "count wrapped on append")

endmodule

`default_nettype wire

// File: src/ole_ctrl.sv
// Controller state machine of the ordered list engine. Sequences RAM
// accesses and result beats through dp_cmd_t; uses ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ole_ctrl import ole_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire mode_t      item_mode,
  input  wire dp_status_t status,
  output logic            item_stall,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (item_mode)
            MODE_APPEND: state_next = S_APPEND;
            MODE_DELETE: state_next = S_SCAN_REQ;
            MODE_SWAP:   state_next = S_SWAP_RD1;
            MODE_READ:   state_next = S_READ_REQ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_APPEND:    state_next = S_RESULT;
      S_SCAN_REQ:  state_next = status.idx_at_end ? S_RESULT : S_SCAN_CMP;
      S_SCAN_CMP:  state_next = status.match ? S_SHIFT_REQ : S_SCAN_REQ;
      S_SHIFT_REQ: state_next = status.idx_last ? S_RESULT : S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_REQ;
      S_SWAP_RD1:  state_next = status.short_list ? S_RESULT : S_SWAP_RD2;
      S_SWAP_RD2:  state_next = S_SWAP_WR1;
      S_SWAP_WR1:  state_next = S_SWAP_WR2;
      S_SWAP_WR2:  state_next = S_RESULT;
      S_READ_REQ:  state_next = status.empty ? S_RESULT : S_READ_EMIT;
      S_READ_EMIT: begin
        if (status.slot_free) begin
          state_next = status.idx_last ? S_IDLE : S_READ_REQ;
        end
      end
      S_RESULT: begin
        if (status.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.capture = item_valid;
      end
      S_APPEND: begin
        if (status.full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_FULL;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = ASEL_COUNT;
          cmd.wdata_sel = WSEL_KEY;
          cmd.cnt_inc   = 1'b1;
        end
      end
      S_SCAN_REQ: begin
        if (status.idx_at_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_NOT_FOUND;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ASEL_IDX;
        end
      end
      S_SCAN_CMP: begin
        cmd.idx_inc = !status.match;
      end
      S_SHIFT_REQ: begin
        if (status.idx_last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ASEL_IDX_P1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = ASEL_IDX;
        cmd.wdata_sel = WSEL_RDATA;
        cmd.idx_inc   = 1'b1;
      end
      S_SWAP_RD1: begin
        if (status.short_list) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_SHORT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ASEL_ONE;
        end
      end
      S_SWAP_RD2: begin
        cmd.tmp_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = ASEL_LAST;
      end
      S_SWAP_WR1: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = ASEL_ONE;
        cmd.wdata_sel = WSEL_RDATA;
      end
      S_SWAP_WR2: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = ASEL_LAST;
        cmd.wdata_sel = WSEL_TMP;
      end
      S_READ_REQ: begin
        if (!status.empty) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ASEL_IDX;
        end
      end
      S_READ_EMIT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_elem = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_RESULT: begin
        cmd.out_load = status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/ordered_list_engine.sv
// Top level of the ordered list engine: bounded ordered list of signed words.
// Instantiates ole_ctrl and ole_datapath; uses ole_pkg.
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat per operation,
//     item.mode selects append, delete first match, swap second and last,
//     or read out; item.value is the word to append or the key to delete.
//   result channel (result_valid / result_stall / result): one beat per
//     operation, or one beat per entry on read out with result.last set on
//     the final one. An empty read out gives a single beat with last set.
//   A beat moves at a rising edge with valid high and stall low.
// Sequencing (one item at a time; the next item is taken only after its result is loaded):
//   a swap on a list that is too short ends early with a short status. The entry RAM
//   has one write and one read port with a registered read, so each entry moved or
//   inspected takes a read state and then a compare or write state.
// item_stall is low only while the controller is idle, after each result load;
//   a new item is taken while the previous result waits in the output register.
// Reset empties the list; RAM contents are not cleared, only the count.
// When the receiver stalls, the result register holds its beat and the
//   controller waits before loading the next one.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine import ole_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequence the operation; the mode is only looked at on the accept beat
  ole_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // hold the list, the key and the result beat
  ole_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_value   (item.value),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
